// File: hw/rtl/wfpf_pkg.sv
// Package for the whisker fork pairing filter: payload structs, control word
// layout, lane and phase codes, and the microcode store of the sequencer.
// No dependencies.
package wfpf_pkg;

  // Field and datapath widths
  localparam int unsigned CntW    = 8;
  localparam int unsigned QW      = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned XW      = 24;
  localparam int unsigned RunW    = 11;
  localparam int unsigned StageW  = 3;
  localparam int unsigned StepW   = 3;
  localparam int unsigned NumQ    = 4;
  localparam int unsigned QIdxW   = $clog2(NumQ);
  localparam int unsigned CfgIdxW = 3;

  // Largest strand count accepted as a valid whisker
  localparam int unsigned MaxCount = 255;

  // Reset values of the test points
  localparam logic [QW-1:0] TestQReset [NumQ] = '{16'd3, 16'd5, 16'd7, 16'd11};

  // Result stage codes
  localparam logic [StageW-1:0] StagePass  = 3'd0;
  localparam logic [StageW-1:0] StageShape = 3'd1;
  localparam logic [StageW-1:0] StageQ0    = 3'd2;

  // Microcode step addresses
  localparam logic [StepW-1:0] StIdle = 3'd0;
  localparam logic [StepW-1:0] StSq   = 3'd1;
  localparam logic [StepW-1:0] StQ4   = 3'd2;
  localparam logic [StepW-1:0] StBot  = 3'd3;
  localparam logic [StepW-1:0] StTop  = 3'd4;
  localparam logic [StepW-1:0] StFin  = 3'd5;
  localparam logic [StepW-1:0] StFail = 3'd6;

  typedef logic signed [XW-1:0]   pos_t;
  typedef logic signed [RunW-1:0] run_t;

  typedef struct packed {
    logic [CntW-1:0] count_a;
    logic [CntW-1:0] count_b;
    logic [CntW-1:0] count_c;
    logic [CntW-1:0] count_d;
    logic [CntW-1:0] count_e;
  } in_item_t;

  typedef struct packed {
    logic              passes;
    logic [StageW-1:0] fail_stage;
  } out_item_t;

  // Datapath phase selected by the control word
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SQ,
    PH_Q4,
    PH_BOT,
    PH_TOP,
    PH_FIN,
    PH_FAIL
  } phase_e;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NONE,
    JC_START,
    JC_RANGE,
    JC_BAND,
    JC_STOP,
    JC_OUTBUSY
  } cond_e;

  // Lane operations on the polynomial value pv and monomial mv
  typedef enum logic [3:0] {
    LN_HOLD,
    LN_SQ,
    LN_Q4,
    LN_UP_L,
    LN_DN_L,
    LN_DN_R,
    LN_UP_R,
    LN_PQ,
    LN_MQ,
    LN_PQ4,
    LN_MQ4
  } lane_op_e;

  typedef struct packed {
    phase_e           phase;
    cond_e            cond;
    logic [StepW-1:0] jump;
    logic [StepW-1:0] next;
  } ctrl_word_t;

  // Status that the sequencer branches on
  typedef struct packed {
    logic start;
    logic out_busy;
    logic range_fail;
    logic band_fail;
    logic at_stop;
  } seq_flags_t;

  // Control store: one word per step
  function automatic ctrl_word_t ucode_rom(input logic [StepW-1:0] step);
    ctrl_word_t w;
    unique case (step)
      StIdle:  w = '{phase: PH_IDLE, cond: JC_START,   jump: StSq,   next: StIdle};
      StSq:    w = '{phase: PH_SQ,   cond: JC_RANGE,   jump: StFail, next: StQ4};
      StQ4:    w = '{phase: PH_Q4,   cond: JC_NONE,    jump: StBot,  next: StBot};
      StBot:   w = '{phase: PH_BOT,  cond: JC_BAND,    jump: StFail, next: StTop};
      StTop:   w = '{phase: PH_TOP,  cond: JC_STOP,    jump: StFin,  next: StBot};
      StFin:   w = '{phase: PH_FIN,  cond: JC_OUTBUSY, jump: StFin,  next: StIdle};
      StFail:  w = '{phase: PH_FAIL, cond: JC_OUTBUSY, jump: StFail, next: StIdle};
      default: w = '{phase: PH_IDLE, cond: JC_NONE,    jump: StIdle, next: StIdle};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/wfpf_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on wfpf_pkg.
module wfpf_seq import wfpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ctrl_word_t ctrl_o
);

  logic [StepW-1:0] step_q, step_d;
  ctrl_word_t       ctrl;
  logic             take_jump;

  assign ctrl   = ucode_rom(step_q);
  assign ctrl_o = ctrl;

  // Evaluate the jump condition of the current word
  always_comb begin
    unique case (ctrl.cond)
      JC_NONE:    take_jump = 1'b0;
      JC_START:   take_jump = flags_i.start;
      JC_RANGE:   take_jump = flags_i.range_fail;
      JC_BAND:    take_jump = flags_i.band_fail;
      JC_STOP:    take_jump = flags_i.at_stop;
      JC_OUTBUSY: take_jump = flags_i.out_busy;
      default:    take_jump = 1'b0;
    endcase
    step_d = take_jump ? ctrl.jump : ctrl.next;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef ASSERT_OFF
  // A bottom-row step that stays in the band is followed by a top-row step
  a_bot_then_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.phase == PH_BOT && !flags_i.band_fail) |=> ctrl.phase == PH_TOP)
    else $error("bottom step not followed by top step");
`endif

endmodule

// File: hw/rtl/wfpf_lane.sv
// One evaluation lane: polynomial value and monomial at one test point,
// with a single shared 32-bit multiplier. Depends on wfpf_pkg.
module wfpf_lane import wfpf_pkg::*; (
  input  logic            clk_i,
  input  lane_op_e        op_i,
  input  logic [QW-1:0]   q_i,
  output logic            pv_nz_o
);

  logic [WordW-1:0] pv_q, pv_d;
  logic [WordW-1:0] mv_q, mv_d;
  logic [WordW-1:0] q4_q, q4_d;
  logic [WordW-1:0] mul_a, mul_b, prod;
  logic [WordW-1:0] q_ext;

  assign q_ext   = WordW'(q_i);
  assign prod    = mul_a * mul_b;
  assign pv_nz_o = (pv_q != '0);

  // Select multiplier operands and the updates of each operation
  always_comb begin
    mul_a = pv_q;
    mul_b = q_ext;
    pv_d  = pv_q;
    mv_d  = mv_q;
    q4_d  = q4_q;
    unique case (op_i)
      LN_HOLD: ;
      LN_SQ: begin
        mul_a = q_ext;
        q4_d  = prod;
      end
      LN_Q4: begin
        mul_a = q4_q;
        mul_b = q4_q;
        q4_d  = prod;
        pv_d  = '0;
        mv_d  = WordW'(1);
      end
      LN_UP_L: begin
        mul_a = mv_q;
        mv_d  = prod;
        pv_d  = pv_q + prod;
      end
      LN_DN_L: begin
        mul_a = pv_q - mv_q;
        pv_d  = prod;
      end
      LN_DN_R: begin
        mul_a = mv_q;
        pv_d  = pv_q - mv_q;
        mv_d  = prod;
      end
      LN_UP_R: begin
        pv_d  = prod + mv_q;
      end
      LN_PQ: begin
        pv_d  = prod;
      end
      LN_MQ: begin
        mul_a = mv_q;
        mv_d  = prod;
      end
      LN_PQ4: begin
        mul_b = q4_q;
        pv_d  = prod;
      end
      LN_MQ4: begin
        mul_a = mv_q;
        mul_b = q4_q;
        mv_d  = prod;
      end
      default: ;
    endcase
  end

  // Hold lane values
  always_ff @(posedge clk_i) begin
    pv_q <= pv_d;
    mv_q <= mv_d;
    q4_q <= q4_d;
  end

endmodule

// File: hw/rtl/wfpf_path.sv
// Strand path datapath: latched geometry, position, running sum and remaining
// crossings; picks the lane operation of each step. Depends on wfpf_pkg.
module wfpf_path import wfpf_pkg::*; (
  input  logic       clk_i,
  input  logic       start_i,
  input  in_item_t   item_i,
  input  phase_e     phase_i,
  output lane_op_e   lane_op_o,
  output logic       range_fail_o,
  output logic       band_fail_o,
  output logic       at_stop_o,
  output logic       togo_nz_o
);

  // Geometry of the whisker
  pos_t a_q, d_q, left_b_q, begin_q, left_c_q, stop_q, left_e_q, right_e_q;
  pos_t mir_a_q, mir_b_q, mir_c_q, mir_d_q, mir_e_q;
  run_t togo0_q;
  logic range_q;

  pos_t a_n, b_n, c_n, d_n, e_n;
  pos_t left_b_n, begin_n, left_c_n, stop_n, left_e_n, right_e_n;

  pos_t x_q, x_d;
  run_t run_q, run_d;
  run_t togo_q, togo_d;
  run_t bot_run, bot_togo;
  pos_t bot_x, top_x;
  lane_op_e bot_op, top_op;

  assign a_n       = pos_t'(item_i.count_a);
  assign b_n       = pos_t'(item_i.count_b);
  assign c_n       = pos_t'(item_i.count_c);
  assign d_n       = pos_t'(item_i.count_d);
  assign e_n       = pos_t'(item_i.count_e);
  assign left_b_n  = a_n + a_n;
  assign begin_n   = left_b_n + b_n;
  assign left_c_n  = begin_n + b_n + pos_t'(1);
  assign stop_n    = left_c_n + c_n;
  assign left_e_n  = d_n + d_n;
  assign right_e_n = left_e_n + e_n;

  // Latch geometry on transfer
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q       <= a_n;
      d_q       <= d_n;
      left_b_q  <= left_b_n;
      begin_q   <= begin_n;
      left_c_q  <= left_c_n;
      stop_q    <= stop_n;
      left_e_q  <= left_e_n;
      right_e_q <= right_e_n;
      mir_a_q   <= left_b_n - pos_t'(1);
      mir_b_q   <= begin_n + begin_n;
      mir_c_q   <= stop_n + stop_n;
      mir_d_q   <= left_e_n - pos_t'(1);
      mir_e_q   <= right_e_n + right_e_n - pos_t'(1);
      togo0_q   <= run_t'(item_i.count_d) + run_t'(item_i.count_e);
      range_q   <= (32'(item_i.count_a) > MaxCount) || (32'(item_i.count_b) > MaxCount) ||
                   (32'(item_i.count_c) > MaxCount) || (32'(item_i.count_d) > MaxCount) ||
                   (32'(item_i.count_e) > MaxCount);
    end
  end

  // Bottom row step
  always_comb begin
    if (x_q < left_e_q) begin
      if (x_q < d_q) begin
        bot_op  = LN_UP_L;
        bot_run = run_q + run_t'(1);
      end else begin
        bot_op  = LN_DN_L;
        bot_run = run_q - run_t'(1);
      end
      bot_x = mir_d_q - x_q;
    end else begin
      if (x_q < right_e_q) begin
        bot_op  = LN_DN_R;
        bot_run = run_q - run_t'(1);
      end else begin
        bot_op  = LN_UP_R;
        bot_run = run_q + run_t'(1);
      end
      bot_x = mir_e_q - x_q;
    end
    bot_togo = togo_q - run_t'(1);
  end

  // Top row step
  always_comb begin
    if (x_q < left_c_q) begin
      if (x_q < left_b_q) begin
        top_op = (x_q < a_q) ? LN_PQ : LN_MQ;
        top_x  = mir_a_q - x_q;
      end else begin
        top_op = (x_q < begin_q) ? LN_MQ4 : LN_PQ4;
        top_x  = mir_b_q - x_q;
      end
    end else if (x_q == stop_q) begin
      top_op = LN_HOLD;
      top_x  = x_q;
    end else begin
      top_op = (x_q < stop_q) ? LN_PQ : LN_MQ;
      top_x  = mir_c_q - x_q;
    end
  end

  assign band_fail_o  = (bot_run > bot_togo) || (bot_run < -bot_togo);
  assign at_stop_o    = (x_q == stop_q);
  assign togo_nz_o    = (togo_q != '0);
  assign range_fail_o = range_q;

  // Select the step of the current phase
  always_comb begin
    x_d       = x_q;
    run_d     = run_q;
    togo_d    = togo_q;
    lane_op_o = LN_HOLD;
    unique case (phase_i)
      PH_SQ: lane_op_o = LN_SQ;
      PH_Q4: begin
        lane_op_o = LN_Q4;
        x_d       = begin_q;
        run_d     = '0;
        togo_d    = togo0_q;
      end
      PH_BOT: begin
        lane_op_o = bot_op;
        x_d       = bot_x;
        run_d     = bot_run;
        togo_d    = bot_togo;
      end
      PH_TOP: begin
        lane_op_o = top_op;
        x_d       = top_x;
      end
      default: ;
    endcase
  end

  // Hold walk position and counters
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    run_q  <= run_d;
    togo_q <= togo_d;
  end

endmodule

// File: hw/rtl/whisker_fork_pairing_filter_top.sv
// Top level of the whisker fork pairing filter: channels, test point registers,
// result register; instantiates wfpf_seq, wfpf_path and wfpf_lane. Uses wfpf_pkg.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_data_i (count_a..count_e)
// out       output     out_valid_o/out_stall_i out_data_o (passes, fail_stage)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// After transfer an item runs the squaring and Q4 steps, then strand steps until
// the walk reaches the stop after n strand steps (n = d+e), or until it is rejected
// on the bottom row of step n (n at most d+e+1); a finishing step loads the result.
// Each strand step runs on the bottom row and then on the top row, with
// all four test points updated in parallel by one multiplier per lane.
// Reset puts the sequencer idle and the test points at 3, 5, 7 and 11.
// A result waiting on out_stall_i holds the sequencer only when a second
// result is ready; the next item is accepted while a result waits.
module whisker_fork_pairing_filter_top import wfpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [QW-1:0]      cfg_data_i
);

  logic [QW-1:0] test_q_q [NumQ];
  ctrl_word_t    ctrl;
  seq_flags_t    flags;
  lane_op_e      lane_op;
  logic          start;
  logic          range_fail, band_fail, at_stop, togo_nz;
  logic [NumQ-1:0] pv_nz;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_data_q, out_data_d;
  logic          out_busy, res_write;
  logic [StageW-1:0] stage;

  assign in_stall_o  = (ctrl.phase != PH_IDLE);
  assign start       = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Write test point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumQ; k++) begin
        test_q_q[k] <= TestQReset[k];
      end
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumQ))) begin
      test_q_q[cfg_index_i[QIdxW-1:0]] <= cfg_data_i;
    end
  end

  assign flags = '{start: start, out_busy: out_busy, range_fail: range_fail,
                   band_fail: band_fail, at_stop: at_stop};

  wfpf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  wfpf_path u_path (
    .clk_i        (clk_i),
    .start_i      (start),
    .item_i       (in_data_i),
    .phase_i      (ctrl.phase),
    .lane_op_o    (lane_op),
    .range_fail_o (range_fail),
    .band_fail_o  (band_fail),
    .at_stop_o    (at_stop),
    .togo_nz_o    (togo_nz)
  );

  for (genvar g = 0; g < NumQ; g++) begin : g_lane
    wfpf_lane u_lane (
      .clk_i   (clk_i),
      .op_i    (lane_op),
      .q_i     (test_q_q[g]),
      .pv_nz_o (pv_nz[g])
    );
  end

  // Pick the first failing stage
  always_comb begin
    stage = StagePass;
    for (int k = NumQ - 1; k >= 0; k--) begin
      if (pv_nz[k]) begin
        stage = StageQ0 + StageW'(k);
      end
    end
    if (ctrl.phase == PH_FAIL || togo_nz) begin
      stage = StageShape;
    end
  end

  // Load the result register when the sequencer finishes
  assign out_busy  = out_valid_q && out_stall_i;
  assign res_write = (ctrl.phase == PH_FIN || ctrl.phase == PH_FAIL) && !out_busy;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (res_write) begin
      out_valid_d           = 1'b1;
      out_data_d.passes     = (stage == StagePass);
      out_data_d.fail_stage = stage;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // An accepted item starts the program at the squaring step
  a_start_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> ctrl.phase == PH_SQ)
    else $error("transfer did not start the program");

  // A new result appears only after a finishing step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(ctrl.phase) == PH_FIN || $past(ctrl.phase) == PH_FAIL))
    else $error("result without finishing step");

  // The passes flag agrees with the stage code
  a_pass_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.passes == (out_data_q.fail_stage == StagePass)))
    else $error("passes flag and stage disagree");
`endif

endmodule
